@@ design/rsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and constants of the RESP2 stream parser.
// ----------------------------------------------------------------------------
package rsp_pkg;

   localparam int MAX_DEPTH = 8;
   localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W     = 63;

   // event codes
   localparam logic [3:0] EV_NONE        = 4'd0;
   localparam logic [3:0] EV_SIMPLE_BYTE = 4'd1;
   localparam logic [3:0] EV_ERROR_BYTE  = 4'd2;
   localparam logic [3:0] EV_BULK_BYTE   = 4'd3;
   localparam logic [3:0] EV_SIMPLE_END  = 4'd4;
   localparam logic [3:0] EV_ERROR_END   = 4'd5;
   localparam logic [3:0] EV_INTEGER     = 4'd6;
   localparam logic [3:0] EV_BULK_END    = 4'd7;
   localparam logic [3:0] EV_NULL_BULK   = 4'd8;
   localparam logic [3:0] EV_ARRAY_START = 4'd9;
   localparam logic [3:0] EV_BULK_START  = 4'd10;

   // error codes
   localparam logic [3:0] ERR_OK        = 4'd0;
   localparam logic [3:0] ERR_BAD_INT   = 4'd1;
   localparam logic [3:0] ERR_BAD_BLEN  = 4'd2;
   localparam logic [3:0] ERR_NEG_BULK  = 4'd3;
   localparam logic [3:0] ERR_NO_CRLF   = 4'd4;
   localparam logic [3:0] ERR_BAD_ALEN  = 4'd5;
   localparam logic [3:0] ERR_NEG_ARRAY = 4'd6;
   localparam logic [3:0] ERR_BAD_TYPE  = 4'd7;
   localparam logic [3:0] ERR_TOO_DEEP  = 4'd8;

   // stream characters
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef struct packed {
      logic [3:0]         event_res;
      logic [7:0]         payload_byte;
      logic signed [63:0] number;
      logic               value_done;
      logic [3:0]         error_code;
      logic               last;
   } res_type;

   typedef struct packed {
      logic             clear;
      logic             pop;
      logic             push;
      logic [CNT_W-1:0] value;
   } stk_ctl_type;

   typedef struct packed {
      logic             done;
      logic             full;
      logic [LVL_W-1:0] level;
   } stk_sts_type;

endpackage
`default_nettype wire

@@ design/rsp_stack.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_stack
// Open-array count stack; one finished element pops all exhausted levels.
// ----------------------------------------------------------------------------
module rsp_stack (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rsp_pkg::stk_ctl_type ctl,
   output rsp_pkg::stk_sts_type      sts
);
   logic [rsp_pkg::LVL_W-1:0] level_ff;
   logic [rsp_pkg::LVL_W-1:0] level_in;
   logic [rsp_pkg::CNT_W-1:0] cnt_ff [rsp_pkg::MAX_DEPTH];
   logic [rsp_pkg::LVL_W-1:0] lvl_eff;
   logic [rsp_pkg::IDX_W-1:0] top_idx;
   logic                      any_keep;

   // highest open level whose count stays nonzero after a decrement
   always_comb begin
      lvl_eff  = ctl.clear ? '0 : level_ff;
      top_idx  = '0;
      any_keep = 1'b0;
      for (int i = 0; i < rsp_pkg::MAX_DEPTH; i++) begin
         if ((rsp_pkg::LVL_W'(i) < lvl_eff) && (cnt_ff[i] != rsp_pkg::CNT_W'(1))) begin
            top_idx  = rsp_pkg::IDX_W'(i);
            any_keep = 1'b1;
         end
      end
      if (ctl.pop) begin
         level_in = any_keep ? rsp_pkg::LVL_W'(top_idx) + rsp_pkg::LVL_W'(1) : '0;
      end else if (ctl.push) begin
         level_in = lvl_eff + rsp_pkg::LVL_W'(1);
      end else begin
         level_in = lvl_eff;
      end
   end

   assign sts.done  = !any_keep;
   assign sts.full  = (lvl_eff >= rsp_pkg::LVL_W'(rsp_pkg::MAX_DEPTH));
   assign sts.level = level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pop && any_keep) begin
         cnt_ff[top_idx] <= cnt_ff[top_idx] - rsp_pkg::CNT_W'(1);
      end else if (ctl.push) begin
         cnt_ff[lvl_eff[rsp_pkg::IDX_W-1:0]] <= ctl.value;
      end
   end
endmodule
`default_nettype wire

@@ design/rsp_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_core
// Per-byte parse step: phase, number accumulator, string and bulk state.
// ----------------------------------------------------------------------------
module rsp_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 restart,
   input  wire rsp_pkg::stk_sts_type stk_sts,
   output rsp_pkg::stk_ctl_type      stk_ctl,
   output logic [1:0]                res_n,
   output rsp_pkg::res_type          res0,
   output rsp_pkg::res_type          res1
);
   typedef enum logic [2:0] {
      PH_TYPE, PH_LINE, PH_NUM, PH_BODY, PH_BCR, PH_BLF
   } phase_type;

   typedef enum logic [2:0] {
      VT_SIMPLE, VT_ERROR, VT_INT, VT_BULK, VT_ARRAY
   } vt_type;

   phase_type   phase_ff, phase_in, ph_eff;
   vt_type      vtype_ff, vtype_in, vt_eff;
   logic [63:0] acc_ff, acc_in, acc_eff;
   logic        neg_ff, neg_in, neg_eff;
   logic        digit_ff, digit_in, digit_eff;
   logic        held_ff, held_in, held_eff;
   logic [62:0] bulk_ff, bulk_in, bulk_eff;
   logic        failed_ff, failed_in, failed_eff;

   logic [3:0]  num_code;
   logic [3:0]  pay_ev;
   logic [67:0] acc_next;
   logic [67:0] limit;
   logic [63:0] neg_bits;
   logic        pop_req, push_req;
   rsp_pkg::res_type r0, r1;
   logic [1:0]  n;

   function automatic rsp_pkg::res_type mk(input logic [3:0] ev, input logic [7:0] pay,
                                           input logic [63:0] num, input logic done,
                                           input logic [3:0] err);
      rsp_pkg::res_type r;
      r.event_res    = ev;
      r.payload_byte = pay;
      r.number       = num;
      r.value_done   = done;
      r.error_code   = err;
      r.last         = 1'b0;
      return r;
   endfunction

   always_comb begin
      ph_eff     = restart ? PH_TYPE : phase_ff;
      vt_eff     = restart ? VT_SIMPLE : vtype_ff;
      acc_eff    = restart ? '0 : acc_ff;
      neg_eff    = restart ? 1'b0 : neg_ff;
      digit_eff  = restart ? 1'b0 : digit_ff;
      held_eff   = restart ? 1'b0 : held_ff;
      bulk_eff   = restart ? '0 : bulk_ff;
      failed_eff = restart ? 1'b0 : failed_ff;

      phase_in  = ph_eff;
      vtype_in  = vt_eff;
      acc_in    = acc_eff;
      neg_in    = neg_eff;
      digit_in  = digit_eff;
      held_in   = held_eff;
      bulk_in   = bulk_eff;
      failed_in = failed_eff;
      pop_req   = 1'b0;
      push_req  = 1'b0;
      r0        = mk(rsp_pkg::EV_NONE, 8'd0, 64'd0, 1'b0, rsp_pkg::ERR_OK);
      r1        = r0;
      n         = 2'd0;

      if (vt_eff == VT_BULK) begin
         num_code = rsp_pkg::ERR_BAD_BLEN;
      end else if (vt_eff == VT_ARRAY) begin
         num_code = rsp_pkg::ERR_BAD_ALEN;
      end else begin
         num_code = rsp_pkg::ERR_BAD_INT;
      end
      pay_ev   = (vt_eff == VT_ERROR) ? rsp_pkg::EV_ERROR_BYTE : rsp_pkg::EV_SIMPLE_BYTE;
      // acc * 10 + digit, compared against the signed range bound
      acc_next = {1'b0, acc_eff, 3'b000} + {3'b000, acc_eff, 1'b0}
               + {60'd0, data_byte - rsp_pkg::CH_ZERO};
      limit    = neg_eff ? {4'd0, 64'h8000_0000_0000_0000}
                         : {4'd0, 64'h7FFF_FFFF_FFFF_FFFF};
      neg_bits = ~acc_eff + 64'd1;

      if (!failed_eff) begin
         unique case (ph_eff)
            PH_TYPE: begin
               acc_in   = '0;
               neg_in   = 1'b0;
               digit_in = 1'b0;
               held_in  = 1'b0;
               unique case (data_byte)
                  rsp_pkg::CH_PLUS:   begin vtype_in = VT_SIMPLE; phase_in = PH_LINE; end
                  rsp_pkg::CH_MINUS:  begin vtype_in = VT_ERROR;  phase_in = PH_LINE; end
                  rsp_pkg::CH_COLON:  begin vtype_in = VT_INT;    phase_in = PH_NUM;  end
                  rsp_pkg::CH_DOLLAR: begin vtype_in = VT_BULK;   phase_in = PH_NUM;  end
                  rsp_pkg::CH_STAR:   begin vtype_in = VT_ARRAY;  phase_in = PH_NUM;  end
                  default: begin
                     failed_in = 1'b1;
                     r0 = mk(rsp_pkg::EV_NONE, 8'd0, 64'd0, 1'b0, rsp_pkg::ERR_BAD_TYPE);
                     n  = 2'd1;
                  end
               endcase
            end
            PH_LINE: begin
               held_in = 1'b0;
               if (held_eff && data_byte == rsp_pkg::CH_LF) begin
                  phase_in = PH_TYPE;
                  pop_req  = 1'b1;
                  r0 = mk(pay_ev + 4'd3, 8'd0, 64'd0, stk_sts.done, rsp_pkg::ERR_OK);
                  n  = 2'd1;
               end else begin
                  // a held CR that is not part of CRLF goes out as payload
                  if (held_eff) begin
                     r0 = mk(pay_ev, rsp_pkg::CH_CR, 64'd0, 1'b0, rsp_pkg::ERR_OK);
                  end
                  if (data_byte == rsp_pkg::CH_CR) begin
                     held_in = 1'b1;
                     n = held_eff ? 2'd1 : 2'd0;
                  end else if (held_eff) begin
                     r1 = mk(pay_ev, data_byte, 64'd0, 1'b0, rsp_pkg::ERR_OK);
                     n  = 2'd2;
                  end else begin
                     r0 = mk(pay_ev, data_byte, 64'd0, 1'b0, rsp_pkg::ERR_OK);
                     n  = 2'd1;
                  end
               end
            end
            PH_NUM: begin
               n = 2'd1;
               if (held_eff) begin
                  held_in = 1'b0;
                  if (data_byte == rsp_pkg::CH_LF && digit_eff) begin
                     phase_in = PH_TYPE;
                     priority if (vt_eff == VT_INT) begin
                        pop_req = 1'b1;
                        r0 = mk(rsp_pkg::EV_INTEGER, 8'd0, neg_eff ? neg_bits : acc_eff,
                                stk_sts.done, rsp_pkg::ERR_OK);
                     end else if (vt_eff == VT_BULK) begin
                        if (neg_eff && acc_eff == 64'd1) begin
                           pop_req = 1'b1;
                           r0 = mk(rsp_pkg::EV_NULL_BULK, 8'd0, neg_bits, stk_sts.done,
                                   rsp_pkg::ERR_OK);
                        end else if (neg_eff && acc_eff > 64'd1) begin
                           failed_in = 1'b1;
                           r0 = mk(rsp_pkg::EV_NONE, 8'd0, 64'd0, 1'b0, rsp_pkg::ERR_NEG_BULK);
                        end else begin
                           bulk_in  = acc_eff[62:0];
                           phase_in = (acc_eff == 64'd0) ? PH_BCR : PH_BODY;
                           r0 = mk(rsp_pkg::EV_BULK_START, 8'd0, acc_eff, 1'b0, rsp_pkg::ERR_OK);
                        end
                     end else begin
                        if (neg_eff && acc_eff != 64'd0) begin
                           failed_in = 1'b1;
                           r0 = mk(rsp_pkg::EV_NONE, 8'd0, 64'd0, 1'b0,
                                   rsp_pkg::ERR_NEG_ARRAY);
                        end else if (acc_eff == 64'd0) begin
                           pop_req = 1'b1;
                           r0 = mk(rsp_pkg::EV_ARRAY_START, 8'd0, 64'd0, stk_sts.done,
                                   rsp_pkg::ERR_OK);
                        end else if (stk_sts.full) begin
                           failed_in = 1'b1;
                           r0 = mk(rsp_pkg::EV_NONE, 8'd0, 64'd0, 1'b0, rsp_pkg::ERR_TOO_DEEP);
                        end else begin
                           push_req = 1'b1;
                           r0 = mk(rsp_pkg::EV_ARRAY_START, 8'd0, acc_eff, 1'b0,
                                   rsp_pkg::ERR_OK);
                        end
                     end
                  end else begin
                     failed_in = 1'b1;
                     r0 = mk(rsp_pkg::EV_NONE, 8'd0, 64'd0, 1'b0, num_code);
                  end
               end else if (data_byte == rsp_pkg::CH_CR) begin
                  held_in = 1'b1;
                  n = 2'd0;
               end else if (data_byte == rsp_pkg::CH_MINUS && !neg_eff && !digit_eff) begin
                  neg_in = 1'b1;
                  n = 2'd0;
               end else if (data_byte >= rsp_pkg::CH_ZERO && data_byte <= rsp_pkg::CH_NINE) begin
                  if (acc_next > limit) begin
                     failed_in = 1'b1;
                     r0 = mk(rsp_pkg::EV_NONE, 8'd0, 64'd0, 1'b0, num_code);
                  end else begin
                     acc_in   = acc_next[63:0];
                     digit_in = 1'b1;
                     n = 2'd0;
                  end
               end else begin
                  failed_in = 1'b1;
                  r0 = mk(rsp_pkg::EV_NONE, 8'd0, 64'd0, 1'b0, num_code);
               end
            end
            PH_BODY: begin
               r0 = mk(rsp_pkg::EV_BULK_BYTE, data_byte, 64'd0, 1'b0, rsp_pkg::ERR_OK);
               n  = 2'd1;
               if (bulk_eff != '0) begin
                  bulk_in = bulk_eff - 63'd1;
               end
               if (bulk_eff <= 63'd1) begin
                  phase_in = PH_BCR;
               end
            end
            PH_BCR: begin
               if (data_byte == rsp_pkg::CH_CR) begin
                  phase_in = PH_BLF;
               end else begin
                  failed_in = 1'b1;
                  r0 = mk(rsp_pkg::EV_NONE, 8'd0, 64'd0, 1'b0, rsp_pkg::ERR_NO_CRLF);
                  n  = 2'd1;
               end
            end
            PH_BLF: begin
               n = 2'd1;
               if (data_byte == rsp_pkg::CH_LF) begin
                  phase_in = PH_TYPE;
                  pop_req  = 1'b1;
                  r0 = mk(rsp_pkg::EV_BULK_END, 8'd0, 64'd0, stk_sts.done, rsp_pkg::ERR_OK);
               end else begin
                  failed_in = 1'b1;
                  r0 = mk(rsp_pkg::EV_NONE, 8'd0, 64'd0, 1'b0, rsp_pkg::ERR_NO_CRLF);
               end
            end
            default: begin
               phase_in = PH_TYPE;
            end
         endcase
      end

      if (n == 2'd1) begin
         r0.last = 1'b1;
      end
      if (n == 2'd2) begin
         r1.last = 1'b1;
      end
   end

   assign stk_ctl.clear = fire && restart;
   assign stk_ctl.pop   = fire && pop_req;
   assign stk_ctl.push  = fire && push_req;
   assign stk_ctl.value = acc_eff[62:0];
   assign res_n = fire ? n : 2'd0;
   assign res0  = r0;
   assign res1  = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TYPE;
         vtype_ff  <= VT_SIMPLE;
         acc_ff    <= '0;
         neg_ff    <= 1'b0;
         digit_ff  <= 1'b0;
         held_ff   <= 1'b0;
         bulk_ff   <= '0;
         failed_ff <= 1'b0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         vtype_ff  <= vtype_in;
         acc_ff    <= acc_in;
         neg_ff    <= neg_in;
         digit_ff  <= digit_in;
         held_ff   <= held_in;
         bulk_ff   <= bulk_in;
         failed_ff <= failed_in;
      end
   end
endmodule
`default_nettype wire

@@ design/rsp_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_fifo
// Four-entry result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module rsp_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [1:0]       wr_n,
   input  wire rsp_pkg::res_type wr0,
   input  wire rsp_pkg::res_type wr1,
   output logic                  room,
   output logic                  rd_valid,
   input  wire logic             rd_take,
   output rsp_pkg::res_type      rd_data
);
   rsp_pkg::res_type mem_ff [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       take;

   assign rd_valid = (cnt_ff != 3'd0);
   assign take     = rd_valid && rd_take;
   assign room     = (cnt_ff <= 3'd2);
   assign rd_data  = mem_ff[rp_ff];
   assign wp_in    = wp_ff + wr_n;
   assign rp_in    = rp_ff + {1'b0, take};
   assign cnt_in   = cnt_ff + {1'b0, wr_n} - {2'b00, take};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_n != 2'd0) begin
         mem_ff[wp_ff] <= wr0;
      end
      if (wr_n == 2'd2) begin
         mem_ff[wp_ff + 2'd1] <= wr1;
      end
   end
endmodule
`default_nettype wire

@@ design/resp_stream_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// resp_stream_parser
// Byte-serial RESP2 reply parser with bounded array nesting.
// ----------------------------------------------------------------------------
// Output: the results of a taken byte are registered in the result queue and leave it in order on rsp_.
// Throughput: one byte per cycle while each byte gives at most one result;
//   a byte with two results (CR released as payload) takes two queue entries;
//   input stalls while the four-entry result queue holds three or more.
// Reset: synchronous, clears parser state and the queue; the count stack
//   entries are written before use and are not cleared.
// ----------------------------------------------------------------------------
module resp_stream_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_restart,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_event_res,
   output logic [7:0]       rsp_payload_byte,
   output logic signed [63:0] rsp_number,
   output logic             rsp_value_done,
   output logic [3:0]       rsp_error_code,
   output logic             rsp_last
);
   rsp_pkg::stk_ctl_type stk_ctl;
   rsp_pkg::stk_sts_type stk_sts;
   rsp_pkg::res_type     res0, res1, head;
   logic [1:0]           res_n;
   logic                 room;
   logic                 fire;

   // a byte is taken only when the queue can hold both possible results
   assign req_stall = !room;
   assign fire      = req_valid && room;

   rsp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (req_data_byte),
      .restart   (req_restart),
      .stk_sts   (stk_sts),
      .stk_ctl   (stk_ctl),
      .res_n     (res_n),
      .res0      (res0),
      .res1      (res1)
   );

   // open-array counts; pops cascade in the same cycle as the element end
   rsp_stack u_stack (
      .clock (clock),
      .reset (reset),
      .ctl   (stk_ctl),
      .sts   (stk_sts)
   );

   rsp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_n     (res_n),
      .wr0      (res0),
      .wr1      (res1),
      .room     (room),
      .rd_valid (rsp_valid),
      .rd_take  (!rsp_stall),
      .rd_data  (head)
   );

   assign rsp_event_res    = head.event_res;
   assign rsp_payload_byte = head.payload_byte;
   assign rsp_number       = head.number;
   assign rsp_value_done   = head.value_done;
   assign rsp_error_code   = head.error_code;
   assign rsp_last         = head.last;

   a_two_max: assert property (@(posedge clock) disable iff (reset)
      res_n != 2'd3) else $error("more than two results for one byte");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      stk_sts.level <= rsp_pkg::LVL_W'(rsp_pkg::MAX_DEPTH))
      else $error("stack level past depth");

   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      res_n == 2'd2 |-> !res0.last && res1.last)
      else $error("last mark misplaced on a two-result transfer");

   a_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(stk_ctl.push && stk_ctl.pop)) else $error("push and pop together");
endmodule
`default_nettype wire
